/* sv/bbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared constants, state types and lane control for the bounding box
// diagonal block.
// ----------------------------------------------------------------------------
package bbd_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int DIAG_WIDTH      = 33;
   localparam int AXES            = 3;

   typedef enum logic {
      ST_TAKE,
      ST_LAUNCH
   } top_state_type;

   typedef enum logic [1:0] {
      MG_IDLE,
      MG_SQUARE,
      MG_ROOT,
      MG_HOLD
   } merge_state_type;

   typedef struct packed {
      logic take;
      logic first;
   } bbd_lane_ctl_type;

endpackage
`default_nettype wire

/* sv/bounding_box_diagonal.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounding_box_diagonal
// Axis-aligned bounding box of a vertex set; on the last vertex returns the
// floor square root of the summed squared extents (Q17.16 diagonal).
// ----------------------------------------------------------------------------
//  channel | ports                                    | dir
//  req     | req_valid/ready, req_{x,y,z}_coord,      | in
//          | req_final_vertex                         |
//  rsp     | rsp_valid/ready, rsp_diagonal            | out
//
//  Non-final vertices are taken one per cycle by the three axis lanes.
//  After a final vertex the top stops taking requests until it has handed
//  the box to the merge unit, which then works in the background
//  (shift-add squares, one root bit per cycle); the hand-off of the next
//  final vertex, and every request behind it, waits for the merge unit to
//  be free. The result sits in an output register, so stalls on rsp only
//  hold up the next final vertex.
//  Synchronous reset clears the control state; no clearing pass.
// ----------------------------------------------------------------------------
module bounding_box_diagonal #(
   parameter int COORD_WIDTH = bbd_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [COORD_WIDTH-1:0]          req_x_coord,
   input  wire logic [COORD_WIDTH-1:0]          req_y_coord,
   input  wire logic [COORD_WIDTH-1:0]          req_z_coord,
   input  wire logic                            req_final_vertex,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [bbd_pkg::DIAG_WIDTH-1:0]  rsp_diagonal
);
   import bbd_pkg::*;

   top_state_type    state_ff, state_in;
   logic             seen_ff, seen_in;
   logic             accept;
   logic             start_valid;
   logic             start_ready;
   logic             launched;
   bbd_lane_ctl_type lane_ctl;

   logic [COORD_WIDTH-1:0] ext_x;
   logic [COORD_WIDTH-1:0] ext_y;
   logic [COORD_WIDTH-1:0] ext_z;

   assign accept   = req_valid && req_ready;
   assign launched = start_valid && start_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_TAKE: begin
            if (accept && req_final_vertex) state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            if (start_ready) state_in = ST_TAKE;
         end
         default: state_in = ST_TAKE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      start_valid = 1'b0;
      case (state_ff)
         ST_TAKE:   req_ready   = 1'b1;
         ST_LAUNCH: start_valid = 1'b1;
         default: begin
            req_ready   = 1'b0;
            start_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      seen_in = seen_ff;
      if (launched) begin
         seen_in = 1'b0;
      end else if (accept) begin
         seen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         seen_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
      end
   end

   assign lane_ctl.take  = accept;
   assign lane_ctl.first = !seen_ff;

   bbd_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
      .clock  (clock),
      .ctl    (lane_ctl),
      .coord  (req_x_coord),
      .extent (ext_x)
   );

   bbd_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
      .clock  (clock),
      .ctl    (lane_ctl),
      .coord  (req_y_coord),
      .extent (ext_y)
   );

   bbd_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
      .clock  (clock),
      .ctl    (lane_ctl),
      .coord  (req_z_coord),
      .extent (ext_z)
   );

   bbd_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
      .clock        (clock),
      .reset        (reset),
      .start_valid  (start_valid),
      .start_ready  (start_ready),
      .ext_x        (ext_x),
      .ext_y        (ext_y),
      .ext_z        (ext_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_diagonal (rsp_diagonal)
   );

endmodule
`default_nettype wire

/* sv/bbd_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_lane
// Per-axis min/max tracker. Coordinates are kept in offset-binary form so
// an unsigned compare orders them; extent is max minus min.
// ----------------------------------------------------------------------------
module bbd_lane #(
   parameter int COORD_WIDTH = bbd_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire bbd_pkg::bbd_lane_ctl_type  ctl,
   input  wire logic [COORD_WIDTH-1:0]     coord,
   output logic      [COORD_WIDTH-1:0]     extent
);
   import bbd_pkg::*;

   logic [COORD_WIDTH-1:0] biased;
   logic [COORD_WIDTH-1:0] low_ff;
   logic [COORD_WIDTH-1:0] high_ff;

   assign biased = {~coord[COORD_WIDTH-1], coord[COORD_WIDTH-2:0]};
   assign extent = high_ff - low_ff;

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         if (ctl.first || (biased < low_ff)) begin
            low_ff <= biased;
         end
         if (ctl.first || (biased > high_ff)) begin
            high_ff <= biased;
         end
      end
   end

endmodule
`default_nettype wire

/* sv/bbd_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_merge
// Combines the three lane extents: shift-add sum of squares, then a
// bit-per-cycle integer square root, into a result output register.
// ----------------------------------------------------------------------------
module bbd_merge #(
   parameter int COORD_WIDTH = bbd_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start_valid,
   output logic                                 start_ready,
   input  wire logic [COORD_WIDTH-1:0]          ext_x,
   input  wire logic [COORD_WIDTH-1:0]          ext_y,
   input  wire logic [COORD_WIDTH-1:0]          ext_z,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [bbd_pkg::DIAG_WIDTH-1:0]  rsp_diagonal
);
   import bbd_pkg::*;

   localparam int SUM_W = 2 * COORD_WIDTH + 2;
   localparam int RT_W  = COORD_WIDTH + 1;
   localparam int REM_W = RT_W + 2;
   localparam int CNT_W = $clog2(RT_W);
   localparam int AX_W  = $clog2(AXES);
   localparam int EXT_W = (RT_W > DIAG_WIDTH) ? RT_W : DIAG_WIDTH;

   merge_state_type state_ff, state_in;

   logic [COORD_WIDTH-1:0] ext_ff [AXES];
   logic [AX_W-1:0]        axis_ff;
   logic [AX_W-1:0]        next_axis;
   logic [COORD_WIDTH-1:0] cur_ff;
   logic [SUM_W-1:0]       addend_ff;
   logic [SUM_W-1:0]       acc_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [RT_W-1:0]        root_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [DIAG_WIDTH-1:0]  out_ff;
   logic                   out_valid_ff, out_valid_in;

   logic                   last_axis;
   logic                   load_out;
   logic [REM_W+1:0]       shifted;
   logic [REM_W+1:0]       trial;
   logic                   fits;
   logic [EXT_W-1:0]       root_ext;

   assign next_axis = axis_ff + AX_W'(1);
   assign last_axis = (axis_ff == AX_W'(AXES - 1));
   assign shifted   = {rem_ff, acc_ff[SUM_W-1:SUM_W-2]};
   assign trial     = (REM_W + 2)'({root_ff, 2'b01});
   assign fits      = (shifted >= trial);
   assign root_ext  = EXT_W'(root_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MG_IDLE: begin
            if (start_valid) state_in = MG_SQUARE;
         end
         MG_SQUARE: begin
            if ((cur_ff == '0) && last_axis) state_in = MG_ROOT;
         end
         MG_ROOT: begin
            if (cnt_ff == '0) state_in = MG_HOLD;
         end
         MG_HOLD: begin
            if (!out_valid_ff || rsp_ready) state_in = MG_IDLE;
         end
         default: state_in = MG_IDLE;
      endcase
   end

   always_comb begin
      start_ready = 1'b0;
      load_out    = 1'b0;
      case (state_ff)
         MG_IDLE: start_ready = 1'b1;
         MG_HOLD: load_out = !out_valid_ff || rsp_ready;
         default: begin
            start_ready = 1'b0;
            load_out    = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MG_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         MG_IDLE: begin
            if (start_valid) begin
               ext_ff[0] <= ext_x;
               ext_ff[1] <= ext_y;
               ext_ff[2] <= ext_z;
               cur_ff    <= ext_x;
               addend_ff <= SUM_W'(ext_x);
               acc_ff    <= '0;
               axis_ff   <= '0;
            end
         end
         MG_SQUARE: begin
            if (cur_ff != '0) begin
               if (cur_ff[0]) acc_ff <= acc_ff + addend_ff;
               cur_ff    <= cur_ff >> 1;
               addend_ff <= addend_ff << 1;
            end else if (!last_axis) begin
               axis_ff   <= next_axis;
               cur_ff    <= ext_ff[next_axis];
               addend_ff <= SUM_W'(ext_ff[next_axis]);
            end else begin
               rem_ff  <= '0;
               root_ff <= '0;
               cnt_ff  <= CNT_W'(RT_W - 1);
            end
         end
         MG_ROOT: begin
            acc_ff <= acc_ff << 2;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (fits) begin
               rem_ff  <= REM_W'(shifted - trial);
               root_ff <= {root_ff[RT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= REM_W'(shifted);
               root_ff <= {root_ff[RT_W-2:0], 1'b0};
            end
         end
         MG_HOLD: begin
            if (load_out) out_ff <= root_ext[DIAG_WIDTH-1:0];
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_diagonal = out_ff;

endmodule
`default_nettype wire

/* sv/bbd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks for the bounding box diagonal block, bound to the top.
// ----------------------------------------------------------------------------
module bbd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            req_final_vertex,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [bbd_pkg::DIAG_WIDTH-1:0]  rsp_diagonal
);
   import bbd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_diagonal))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_final_launch: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_vertex |=> !req_ready)
      else $error("request taken during launch cycle");

   a_stream: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_final_vertex |=> req_ready)
      else $error("vertex stream stalled without a final vertex");

endmodule

bind bounding_box_diagonal bbd_checker u_bbd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_final_vertex (req_final_vertex),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_diagonal     (rsp_diagonal)
);
`default_nettype wire
